// ===== rtl/core/sdtd_pkg.sv =====
// Package for the slow-data text decoder: payload types, sync and header
// patterns, unscrambling masks and message geometry. No dependencies.
`default_nettype none

package sdtd_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [4:0] pos_t;
    typedef logic [3:0] step_t;

    localparam byte_t SYNC_0 = 8'h55;
    localparam byte_t SYNC_1 = 8'h2d;
    localparam byte_t SYNC_2 = 8'h16;

    localparam byte_t HDR_SEG0 = 8'h30;
    localparam byte_t HDR_SEG1 = 8'h31;
    localparam byte_t HDR_SEG2 = 8'h32;
    localparam byte_t HDR_SEG3 = 8'h33;

    localparam byte_t XOR_0 = 8'h70;
    localparam byte_t XOR_1 = 8'h4f;
    localparam byte_t XOR_2 = 8'h93;

    localparam int    MSG_LEN  = 20;
    localparam pos_t  LAST_POS = 5'd19;
    localparam byte_t LAST_SEG = 8'd8;

    // request from the sequencer to the message memory
    typedef struct packed {
        logic  we;
        pos_t  waddr;
        byte_t wdata;
        logic  re;
        pos_t  raddr;
    } store_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdtd_frame_if.sv =====
// Input channel of the slow-data text decoder: one voice frame per
// transaction. Depends on sdtd_pkg.
`default_nettype none

interface sdtd_frame_if;
    logic              valid;
    logic              ready;
    sdtd_pkg::byte_t   frame_index;
    sdtd_pkg::byte_t   slow_first;
    sdtd_pkg::byte_t   slow_second;
    sdtd_pkg::byte_t   slow_third;

    modport source (output valid, frame_index, slow_first, slow_second, slow_third,
                    input ready);
    modport sink   (input valid, frame_index, slow_first, slow_second, slow_third,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdtd_char_if.sv =====
// Output channel of the slow-data text decoder: one message character per
// transaction. Depends on sdtd_pkg.
`default_nettype none

interface sdtd_char_if;
    logic              valid;
    logic              ready;
    sdtd_pkg::byte_t   message_char;
    sdtd_pkg::pos_t    char_position;
    logic              last_char;

    modport source (output valid, message_char, char_position, last_char,
                    input ready);
    modport sink   (input valid, message_char, char_position, last_char,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdtd_store.sv =====
// Message memory: 20 x 8, one write port, one read port with registered
// read data that holds while no read is issued. Depends on sdtd_pkg.
`default_nettype none

module sdtd_store (
    input  wire logic                 clk,
    input  wire sdtd_pkg::store_req_t req,
    output logic [7:0]                rdata
);
    import sdtd_pkg::*;

    byte_t mem [MSG_LEN];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sdtd_ctrl.sv =====
// Sequencer: checks frames, writes unscrambled characters into the message
// memory one per cycle and drains the message. Depends on sdtd_pkg and
// the channel interfaces.
`default_nettype none

module sdtd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sdtd_frame_if.sink                 frame_in,
    sdtd_char_if.source                char_out,
    input  wire sdtd_pkg::byte_t       rdata,
    output sdtd_pkg::store_req_t       req
);
    import sdtd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_DRAIN} state_t;

    state_t      state_reg,  state_next;
    logic        synced_reg, synced_next;
    step_t       step_reg,   step_next;
    logic        last_reg,   last_next;
    byte_t       chars_reg [3];
    byte_t       chars_next [3];
    pos_t        base_reg,   base_next;
    logic [1:0]  wend_reg,   wend_next;
    logic [1:0]  wcnt_reg,   wcnt_next;
    pos_t        rptr_reg,   rptr_next;
    pos_t        pos_reg,    pos_next;
    logic        ov_reg,     ov_next;

    logic  accept, is_sync, idx_ok, hdr_ok, take, issue;
    byte_t idx, b0, b1, b2, hdr;

    // first message position written by each frame
    function automatic pos_t base_of(input logic [3:0] i);
        pos_t b;
        case (i)
            4'd1:    b = 5'd0;
            4'd2:    b = 5'd2;
            4'd3:    b = 5'd5;
            4'd4:    b = 5'd7;
            4'd5:    b = 5'd10;
            4'd6:    b = 5'd12;
            4'd7:    b = 5'd15;
            4'd8:    b = 5'd17;
            default: b = 5'd0;
        endcase
        return b;
    endfunction

    always_comb
    begin
        idx = frame_in.frame_index;
        b0  = frame_in.slow_first;
        b1  = frame_in.slow_second;
        b2  = frame_in.slow_third;

        case (idx[2:1])
            2'd0:    hdr = HDR_SEG0;
            2'd1:    hdr = HDR_SEG1;
            2'd2:    hdr = HDR_SEG2;
            default: hdr = HDR_SEG3;
        endcase

        accept  = frame_in.valid && (state_reg == ST_IDLE);
        is_sync = (idx == 8'd0) && (b0 == SYNC_0) && (b1 == SYNC_1) && (b2 == SYNC_2);
        idx_ok  = synced_reg && (idx == {4'd0, step_reg}) && (idx != 8'd0)
                  && (idx <= LAST_SEG);
        hdr_ok  = !idx[0] || (b0 == hdr);
        take    = accept && !is_sync && idx_ok && hdr_ok;
        issue   = (state_reg == ST_DRAIN) && (!ov_reg || char_out.ready);

        state_next  = state_reg;
        synced_next = synced_reg;
        step_next   = step_reg;
        last_next   = last_reg;
        chars_next  = chars_reg;
        base_next   = base_reg;
        wend_next   = wend_reg;
        wcnt_next   = wcnt_reg;
        rptr_next   = rptr_reg;
        pos_next    = pos_reg;
        ov_next     = ov_reg;

        if (issue)
        begin
            ov_next = 1'b1;
        end
        else if (char_out.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_sync)
                begin
                    synced_next = 1'b1;
                    step_next   = 4'd1;
                end
                else if (take)
                begin
                    base_next = base_of(idx[3:0]);
                    wcnt_next = 2'd0;
                    if (idx[0])
                    begin
                        chars_next[0] = b1 ^ XOR_1;
                        chars_next[1] = b2 ^ XOR_2;
                        chars_next[2] = b2 ^ XOR_2;
                        wend_next     = 2'd1;
                    end
                    else
                    begin
                        chars_next[0] = b0 ^ XOR_0;
                        chars_next[1] = b1 ^ XOR_1;
                        chars_next[2] = b2 ^ XOR_2;
                        wend_next     = 2'd2;
                    end
                    if (idx == LAST_SEG)
                    begin
                        synced_next = 1'b0;
                        step_next   = 4'd0;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                        last_next = 1'b0;
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                wcnt_next = wcnt_reg + 2'd1;
                if (wcnt_reg == wend_reg)
                begin
                    rptr_next  = 5'd0;
                    state_next = last_reg ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (issue)
                begin
                    pos_next  = rptr_reg;
                    rptr_next = rptr_reg + 5'd1;
                    if (rptr_reg == LAST_POS)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            synced_reg <= 1'b0;
            step_reg   <= 4'd0;
            last_reg   <= 1'b0;
            wend_reg   <= 2'd0;
            wcnt_reg   <= 2'd0;
            rptr_reg   <= 5'd0;
            pos_reg    <= 5'd0;
            ov_reg     <= 1'b0;
            base_reg   <= 5'd0;
            chars_reg  <= '{default: 8'd0};
        end
        else
        begin
            state_reg  <= state_next;
            synced_reg <= synced_next;
            step_reg   <= step_next;
            last_reg   <= last_next;
            wend_reg   <= wend_next;
            wcnt_reg   <= wcnt_next;
            rptr_reg   <= rptr_next;
            pos_reg    <= pos_next;
            ov_reg     <= ov_next;
            base_reg   <= base_next;
            chars_reg  <= chars_next;
        end
    end

    assign frame_in.ready = (state_reg == ST_IDLE);

    assign req.we    = (state_reg == ST_WRITE);
    assign req.waddr = base_reg + {3'd0, wcnt_reg};
    assign req.wdata = chars_reg[wcnt_reg];
    assign req.re    = issue;
    assign req.raddr = rptr_reg;

    assign char_out.valid         = ov_reg;
    assign char_out.message_char  = rdata;
    assign char_out.char_position = pos_reg;
    assign char_out.last_char     = (pos_reg == LAST_POS);

endmodule

`default_nettype wire

// ===== rtl/core/slow_data_text_decoder.sv =====
// Slow-data text message decoder, top level. Depends on sdtd_pkg, the
// channel interfaces, sdtd_ctrl and sdtd_store.
//
// One voice frame is taken per transaction on frame_in. A frame that carries
// text writes its two or three characters into the message memory at one
// per cycle (memory write port). The eighth frame also drains the whole
// 20-character message on char_out at one character per cycle while
// char_out does not stall, through the memory read port, with the last
// flagged; frame_in is held off until the last read is issued. No clearing
// pass after reset.
`default_nettype none

module slow_data_text_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sdtd_frame_if.sink  frame_in,
    sdtd_char_if.source char_out
);
    import sdtd_pkg::*;

    store_req_t req;
    byte_t      rdata;

    sdtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .char_out (char_out),
        .rdata    (rdata),
        .req      (req)
    );

    sdtd_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sdtd_checker.sv =====
// Port-level checks for slow_data_text_decoder, attached by bind.
// Depends on the top level's channel ports only.
`default_nettype none

module sdtd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic [4:0] out_pos,
    input wire logic       out_last
);

    // a stalled character holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_pos)
                                    && $stable(out_last))
        else $error("stalled character changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_pos == 5'd19)) && (out_pos <= 5'd19))
        else $error("bad position or last flag");

    // characters of a message follow with no gaps in position
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            !out_valid || (out_pos == 5'($past(out_pos) + 5'd1)))
        else $error("character position out of order");

    // new frames are only taken once the message has been fully read out
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_last)
        else $error("frame taken mid-message");

endmodule

bind slow_data_text_decoder sdtd_checker u_sdtd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (frame_in.ready),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.message_char),
    .out_pos   (char_out.char_position),
    .out_last  (char_out.last_char)
);

`default_nettype wire
